>>> hdl/bresenham_line_pixel_stepper_unit_defines.svh
// Assertion macros shared by the line stepper checkers.
`ifndef BRESENHAM_LINE_PIXEL_STEPPER_UNIT_DEFINES_SVH
`define BRESENHAM_LINE_PIXEL_STEPPER_UNIT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BLS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/bls_pkg.sv
// Shared types and constants for the Bresenham line pixel stepper.
package bls_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int CFG_W          = 11;
	localparam int IDX_W          = 20;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(700);
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(700);

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_STEP = 1'b1
	} req_kind_t;

	typedef enum logic {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic pix_valid;
		logic last;
	} pix_ctl_t;

endpackage

>>> hdl/bls_stepper.sv
// Line state registers, load and step logic, and the first pipeline stage.
module bls_stepper
	import bls_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  req_type,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic [COORD_BITS-1:0] x_s1,
	output logic [COORD_BITS-1:0] y_s1,
	output pix_ctl_t              ctl_s1
);

	localparam int ERR_W = COORD_BITS + 3;

	logic [COORD_BITS-1:0]   cur_x_q, cur_y_q, major_end_q, adx_q, ady_q;
	logic signed [ERR_W-1:0] err_q;
	logic                    y_major_q, step_up_q, active_q;

	logic [COORD_BITS-1:0]   nxt_x, nxt_y, nxt_end, nxt_adx, nxt_ady;
	logic signed [ERR_W-1:0] nxt_err;
	logic                    nxt_y_major, nxt_step_up, nxt_active;
	logic                    emit, last;

	logic [COORD_BITS:0]     dx, dy, neg_dx, neg_dy;
	logic [COORD_BITS-1:0]   adx, ady;
	logic                    dx_neg, dy_neg, dx_pos, dy_pos;
	logic [ERR_W-1:0]        adx_e, ady_e, cur_adx_e, cur_ady_e;

	assign dx     = {1'b0, end_x} - {1'b0, start_x};
	assign dy     = {1'b0, end_y} - {1'b0, start_y};
	assign neg_dx = ~dx + 1'b1;
	assign neg_dy = ~dy + 1'b1;
	assign dx_neg = dx[COORD_BITS];
	assign dy_neg = dy[COORD_BITS];
	assign dx_pos = !dx_neg && (dx != '0);
	assign dy_pos = !dy_neg && (dy != '0);
	assign adx    = dx_neg ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
	assign ady    = dy_neg ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

	assign adx_e     = ERR_W'(adx);
	assign ady_e     = ERR_W'(ady);
	assign cur_adx_e = ERR_W'(adx_q);
	assign cur_ady_e = ERR_W'(ady_q);

	always_comb begin
		nxt_x       = cur_x_q;
		nxt_y       = cur_y_q;
		nxt_end     = major_end_q;
		nxt_adx     = adx_q;
		nxt_ady     = ady_q;
		nxt_err     = err_q;
		nxt_y_major = y_major_q;
		nxt_step_up = step_up_q;
		emit        = 1'b0;
		if (req_type == REQ_LOAD) begin
			emit        = 1'b1;
			nxt_adx     = adx;
			nxt_ady     = ady;
			nxt_step_up = (dx_neg && dy_neg) || (dx_pos && dy_pos);
			nxt_y_major = (ady > adx);
			if (ady <= adx) begin
				nxt_err = $signed((ady_e << 1) - adx_e);
				nxt_x   = dx_neg ? end_x : start_x;
				nxt_y   = dx_neg ? end_y : start_y;
				nxt_end = dx_neg ? start_x : end_x;
			end else begin
				nxt_err = $signed((adx_e << 1) - ady_e);
				nxt_x   = dy_neg ? end_x : start_x;
				nxt_y   = dy_neg ? end_y : start_y;
				nxt_end = dy_neg ? start_y : end_y;
			end
		end else if (active_q) begin
			emit = 1'b1;
			if (!y_major_q) begin
				nxt_x = cur_x_q + 1'b1;
				if (err_q[ERR_W-1]) begin
					nxt_err = err_q + $signed(cur_ady_e << 1);
				end else begin
					nxt_y   = step_up_q ? cur_y_q + 1'b1 : cur_y_q - 1'b1;
					nxt_err = err_q + $signed((cur_ady_e - cur_adx_e) << 1);
				end
			end else begin
				nxt_y = cur_y_q + 1'b1;
				if (err_q[ERR_W-1] || (err_q == '0)) begin
					nxt_err = err_q + $signed(cur_adx_e << 1);
				end else begin
					nxt_x   = step_up_q ? cur_x_q + 1'b1 : cur_x_q - 1'b1;
					nxt_err = err_q + $signed((cur_adx_e - cur_ady_e) << 1);
				end
			end
		end
		last       = ((nxt_y_major ? nxt_y : nxt_x) == nxt_end);
		nxt_active = emit ? !last : active_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			major_end_q <= '0;
			adx_q       <= '0;
			ady_q       <= '0;
			err_q       <= '0;
			y_major_q   <= 1'b0;
			step_up_q   <= 1'b0;
			active_q    <= 1'b0;
		end else if (accept) begin
			cur_x_q     <= nxt_x;
			cur_y_q     <= nxt_y;
			major_end_q <= nxt_end;
			adx_q       <= nxt_adx;
			ady_q       <= nxt_ady;
			err_q       <= nxt_err;
			y_major_q   <= nxt_y_major;
			step_up_q   <= nxt_step_up;
			active_q    <= nxt_active;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1             <= nxt_x;
			y_s1             <= nxt_y;
			ctl_s1.pix_valid <= emit;
			ctl_s1.last      <= emit && last;
		end
	end

endmodule

>>> hdl/bls_index.sv
// Clipping, frame buffer index and result register of the line stepper.
module bls_index
	import bls_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  load,
	input  logic [COORD_BITS-1:0] x_s1,
	input  logic [COORD_BITS-1:0] y_s1,
	input  pix_ctl_t              ctl_s1,
	input  logic [CFG_W-1:0]      frame_width,
	input  logic [CFG_W-1:0]      frame_height,
	output logic                  pixel_valid,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [IDX_W-1:0]      frame_index,
	output logic                  in_frame,
	output logic                  line_last
);

	localparam int CMP_W  = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
	localparam int PROD_W = CMP_W + CFG_W;

	logic [CMP_W-1:0]  xe, ye, we, he, rows;
	logic [PROD_W-1:0] prod, sum;
	logic              on_frame;

	logic                  pixel_valid_q, in_frame_q, line_last_q;
	logic [COORD_BITS-1:0] pixel_x_q, pixel_y_q;
	logic [IDX_W-1:0]      frame_index_q;

	assign xe       = CMP_W'(x_s1);
	assign ye       = CMP_W'(y_s1);
	assign we       = CMP_W'(frame_width);
	assign he       = CMP_W'(frame_height);
	assign on_frame = (xe < we) && (ye < he);
	// Buffer row with y flipped: frame_height - 1 - y.
	assign rows   = he - CMP_W'(1) - ye;
	assign prod   = PROD_W'(rows) * PROD_W'(frame_width);
	assign sum    = prod + PROD_W'(x_s1);

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_valid_q <= ctl_s1.pix_valid;
			line_last_q   <= ctl_s1.last;
			pixel_x_q     <= ctl_s1.pix_valid ? x_s1 : '0;
			pixel_y_q     <= ctl_s1.pix_valid ? y_s1 : '0;
			in_frame_q    <= ctl_s1.pix_valid && on_frame;
			frame_index_q <= (ctl_s1.pix_valid && on_frame) ? sum[IDX_W-1:0] : '0;
		end
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign frame_index = frame_index_q;
	assign in_frame    = in_frame_q;
	assign line_last   = line_last_q;

endmodule

>>> hdl/bresenham_line_pixel_stepper_unit.sv
// Top level of the Bresenham line pixel stepper.
// Usage:
//   Request channel (req_valid / req_stall): one transaction per request. req_type
//   REQ_LOAD takes both endpoints and answers with the first pixel of the line;
//   REQ_STEP advances one pixel along the major axis and answers with it.
//   A step after the final pixel answers with pixel_valid low and all fields zero.
//   Result channel (res_valid / res_stall): exactly one result transaction per
//   request, in request order. line_last marks the final pixel of a line.
//   Configuration: cfg_wr_en writes frame_width or frame_height (cfg_index) from
//   cfg_data; write only while no request is in flight.
//   Pipe: an accepted request is registered in stage one, then in the result register.
//   Throughput: one request per cycle while no result waits on res_stall. The line
//   state registers update in the cycle of acceptance (one add and compare); the
//   index multiply sits in the second stage before the result register.
//   Stall: while res_stall holds a waiting result, the whole pipe holds and
//   req_stall rises; otherwise requests keep flowing.
//   Reset: line idle, all line state zero, frame size 700 by 700, pipe empty.
module bresenham_line_pixel_stepper_unit
	import bls_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  req_type,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	// result channel
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic                  pixel_valid,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic [IDX_W-1:0]      frame_index,
	output logic                  in_frame,
	output logic                  line_last,
	// configuration write port
	input  logic                  cfg_wr_en,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	logic                  advance, accept;
	logic                  s1_valid_q, res_valid_q;
	logic [CFG_W-1:0]      frame_width_q, frame_height_q;
	logic [COORD_BITS-1:0] x_s1, y_s1;
	pix_ctl_t              ctl_s1;

	// Advance the pipe unless a finished result is waiting on a stalled receiver.
	assign advance   = !res_valid_q || !res_stall;
	assign req_stall = !advance;
	assign accept    = req_valid && advance;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			s1_valid_q  <= accept;
			res_valid_q <= s1_valid_q;
		end
	end

	// Frame size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_FRAME_WIDTH) begin
				frame_width_q <= cfg_data;
			end else begin
				frame_height_q <= cfg_data;
			end
		end
	end

	// Stage one: line state update and the new pixel coordinates.
	bls_stepper #(
		.COORD_BITS(COORD_BITS)
	) u_stepper (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.req_type(req_type),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.x_s1    (x_s1),
		.y_s1    (y_s1),
		.ctl_s1  (ctl_s1)
	);

	// Stage two: clip, index multiply, result register.
	bls_index #(
		.COORD_BITS(COORD_BITS)
	) u_index (
		.clk         (clk),
		.load        (advance && s1_valid_q),
		.x_s1        (x_s1),
		.y_s1        (y_s1),
		.ctl_s1      (ctl_s1),
		.frame_width (frame_width_q),
		.frame_height(frame_height_q),
		.pixel_valid (pixel_valid),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.frame_index (frame_index),
		.in_frame    (in_frame),
		.line_last   (line_last)
	);

endmodule

>>> hdl/bls_checker.sv
// Port-level checker for the line stepper and its bind statement.
`include "bresenham_line_pixel_stepper_unit_defines.svh"

module bls_checker
	import bls_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  req_stall,
	input logic                  res_valid,
	input logic                  res_stall,
	input logic                  pixel_valid,
	input logic [COORD_BITS-1:0] pixel_x,
	input logic [COORD_BITS-1:0] pixel_y,
	input logic [IDX_W-1:0]      frame_index,
	input logic                  in_frame,
	input logic                  line_last
);

	`BLS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(frame_index) && $stable(line_last), "result changed while stalled")

	`BLS_ASSERT_NOW(a_no_pixel_zero, res_valid && !pixel_valid, pixel_x == '0 && pixel_y == '0 && frame_index == '0 && !in_frame && !line_last, "empty result carries nonzero fields")

	`BLS_ASSERT_NOW(a_clip_index, res_valid && !in_frame, frame_index == '0, "out-of-frame pixel has an index")

	`BLS_ASSERT_NOW(a_stall_cause, !(res_valid && res_stall), !req_stall, "request stalled with no waiting result")

endmodule

bind bresenham_line_pixel_stepper_unit bls_checker #(
	.COORD_BITS(COORD_BITS)
) u_bls_checker (.*);

>>> tb/bls_line_checker.sv
// Checker for the line stepper: predicts each pixel and compares the result stream.
module bls_line_checker
	import bls_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic                      req_stall,
	input  logic                      req_type,
	input  logic [COORD_BITS_DEF-1:0] start_x,
	input  logic [COORD_BITS_DEF-1:0] start_y,
	input  logic [COORD_BITS_DEF-1:0] end_x,
	input  logic [COORD_BITS_DEF-1:0] end_y,
	input  logic                      res_valid,
	input  logic                      res_stall,
	input  logic                      pixel_valid,
	input  logic [COORD_BITS_DEF-1:0] pixel_x,
	input  logic [COORD_BITS_DEF-1:0] pixel_y,
	input  logic [IDX_W-1:0]          frame_index,
	input  logic                      in_frame,
	input  logic                      line_last,
	input  logic                      cfg_wr_en,
	input  logic [0:0]                cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	output int                        fail_count,
	output int                        pending,
	output int                        checked,
	output int                        blank_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = COORD_BITS_DEF;

	typedef logic [CW-1:0] coord_t;

	typedef struct packed {
		logic             pix_valid;
		coord_t           x;
		coord_t           y;
		logic [IDX_W-1:0] idx;
		logic             on_frame;
		logic             last;
	} pixel_t;

	// frame size copy
	logic [CFG_W-1:0] frame_w;
	logic [CFG_W-1:0] frame_h;

	// line state copy
	coord_t pen_x;
	coord_t pen_y;
	coord_t major_stop;
	int     err_acc;
	int     span_dx;
	int     span_dy;
	logic   steep;
	logic   minor_inc;
	logic   drawing;

	pixel_t expected_pixels[$];
	int     mismatches;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("%0t MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Pixel at the current pen position; closes the line at its major end.
	function automatic pixel_t plot_pen();
		pixel_t p;
		int     lin;
		p.pix_valid = 1'b1;
		p.x         = pen_x;
		p.y         = pen_y;
		p.last      = ((steep ? pen_y : pen_x) == major_stop);
		p.on_frame  = (pen_x < frame_w) && (pen_y < frame_h);
		lin         = (int'(frame_h) - 1 - int'(pen_y)) * int'(frame_w) + int'(pen_x);
		p.idx       = p.on_frame ? IDX_W'(lin) : '0;
		drawing     = !p.last;
		return p;
	endfunction

	function automatic pixel_t next_pixel(input logic kind, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey);
		pixel_t p;
		int     dx;
		int     dy;
		if (req_kind_t'(kind) == REQ_LOAD) begin
			dx        = int'(ex) - int'(sx);
			dy        = int'(ey) - int'(sy);
			span_dx   = dx < 0 ? -dx : dx;
			span_dy   = dy < 0 ? -dy : dy;
			minor_inc = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
			if (span_dy <= span_dx) begin
				steep   = 1'b0;
				err_acc = 2 * span_dy - span_dx;
				if (dx >= 0) begin
					pen_x = sx; pen_y = sy; major_stop = ex;
				end else begin
					pen_x = ex; pen_y = ey; major_stop = sx;
				end
			end else begin
				steep   = 1'b1;
				err_acc = 2 * span_dx - span_dy;
				if (dy >= 0) begin
					pen_x = sx; pen_y = sy; major_stop = ey;
				end else begin
					pen_x = ex; pen_y = ey; major_stop = sy;
				end
			end
			return plot_pen();
		end
		if (!drawing) begin
			p = '0;
			return p;
		end
		if (!steep) begin
			pen_x = pen_x + 1'b1;
			if (err_acc < 0) begin
				err_acc += 2 * span_dy;
			end else begin
				pen_y = minor_inc ? pen_y + 1'b1 : pen_y - 1'b1;
				err_acc += 2 * (span_dy - span_dx);
			end
		end else begin
			pen_y = pen_y + 1'b1;
			if (err_acc <= 0) begin
				err_acc += 2 * span_dx;
			end else begin
				pen_x = minor_inc ? pen_x + 1'b1 : pen_x - 1'b1;
				err_acc += 2 * (span_dx - span_dy);
			end
		end
		return plot_pen();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			frame_w    = FRAME_WIDTH_RST;
			frame_h    = FRAME_HEIGHT_RST;
			pen_x      = '0;
			pen_y      = '0;
			major_stop = '0;
			err_acc    = 0;
			span_dx    = 0;
			span_dy    = 0;
			steep      = 1'b0;
			minor_inc  = 1'b0;
			drawing    = 1'b0;
			expected_pixels.delete();
			mismatches = 0;
			checked    = 0;
			blank_seen = 0;
			pending    = 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_reg_t'(cfg_index) == CFG_FRAME_WIDTH)
					frame_w = cfg_data;
				else
					frame_h = cfg_data;
			end
			// compare before queuing, so a result can never meet its own request
			if (res_valid && !res_stall) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("result with nothing pending, pixel_x", pixel_x, 0);
				end else begin
					want = expected_pixels.pop_front();
					checked++;
					if (!want.pix_valid)
						blank_seen++;
					if (pixel_valid !== want.pix_valid)
						report_mismatch("pixel_valid", pixel_valid, want.pix_valid);
					if (pixel_x !== want.x)
						report_mismatch("pixel_x", pixel_x, want.x);
					if (pixel_y !== want.y)
						report_mismatch("pixel_y", pixel_y, want.y);
					if (frame_index !== want.idx)
						report_mismatch("frame_index", frame_index, want.idx);
					if (in_frame !== want.on_frame)
						report_mismatch("in_frame", in_frame, want.on_frame);
					if (line_last !== want.last)
						report_mismatch("line_last", line_last, want.last);
				end
			end
			if (req_valid && !req_stall)
				expected_pixels.push_back(next_pixel(req_type, start_x, start_y, end_x, end_y));
			pending = expected_pixels.size();
		end
	end

endmodule

>>> tb/tb_bresenham_line_pixel_stepper_unit.sv
// Testbench top for the line stepper: drives requests, frame sizes and result back-pressure.
module tb_bresenham_line_pixel_stepper_unit
	import bls_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW         = COORD_BITS_DEF;
	localparam int COORD_MAX  = (1 << CW) - 1;
	localparam int PIPE_DELAY = 2;     // part of the settling wait at the end of a drain
	localparam int HOLD_LEN   = 80;    // long receiver hold-off, in cycles
	localparam int DRAIN_MAX  = 5000;  // bound on any wait for outstanding results

	typedef logic [CW-1:0] coord_t;

	localparam coord_t C_MAX = CW'(COORD_MAX);

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_stall;
	logic             req_type;
	coord_t           start_x;
	coord_t           start_y;
	coord_t           end_x;
	coord_t           end_y;
	logic             res_valid;
	logic             res_stall;
	logic             pixel_valid;
	coord_t           pixel_x;
	coord_t           pixel_y;
	logic [IDX_W-1:0] frame_index;
	logic             in_frame;
	logic             line_last;
	logic             cfg_wr_en;
	logic [0:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int checked;
	int blank_seen;

	// stimulus bookkeeping
	int   loads_sent;
	int   steps_sent;
	int   sizes_used;
	int   x_span;
	int   y_span;
	bit   tx_idle_en;
	bit   rx_idle_en;
	bit   hold_request;

	bresenham_line_pixel_stepper_unit #(.COORD_BITS(CW)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.pixel_valid (pixel_valid),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.frame_index (frame_index),
		.in_frame    (in_frame),
		.line_last   (line_last),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	bls_line_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.pixel_valid (pixel_valid),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.frame_index (frame_index),
		.in_frame    (in_frame),
		.line_last   (line_last),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked),
		.blank_seen  (blank_seen)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: drive stall at the falling edge. A hold request from the
	// sender turns into a long hold-off counted here, so the pipe fills up.
	initial begin
		res_stall <= 1'b1;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_LEN) @(negedge clk);
				res_stall <= 1'b0;
			end else begin
				res_stall <= rx_idle_en && ($urandom_range(0, 99) < 7);
			end
		end
	end

	// Offer one request and wait for the transaction. Valid stays high
	// afterwards, so back-to-back requests drop it only for a random idle gap.
	task automatic push_req(input req_kind_t kind, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey);
		int gap;
		gap = 0;
		if (tx_idle_en && $urandom_range(0, 99) < 7)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req_type  <= kind;
		start_x   <= sx;
		start_y   <= sy;
		end_x     <= ex;
		end_y     <= ey;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		if (kind == REQ_LOAD)
			loads_sent++;
		else
			steps_sent++;
	endtask

	// Step request; the endpoint fields are ignored, so fill them with noise.
	task automatic push_step();
		push_req(REQ_STEP, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
	endtask

	// Drop valid and let every outstanding result come back.
	task automatic drain();
		int n;
		@(negedge clk);
		req_valid <= 1'b0;
		n = 0;
		while (pending != 0 && n < DRAIN_MAX) begin
			@(posedge clk);
			n++;
		end
		repeat (PIPE_DELAY + 2) @(posedge clk);
	endtask

	// Write both frame registers while the block is idle.
	task automatic set_frame(input int fw, input int fh);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_data  <= CFG_W'(fw);
		@(negedge clk);
		cfg_index <= CFG_FRAME_HEIGHT;
		cfg_data  <= CFG_W'(fh);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		x_span = (fw < 1) ? 1 : ((fw > COORD_MAX) ? COORD_MAX : fw);
		y_span = (fh < 1) ? 1 : ((fh > COORD_MAX) ? COORD_MAX : fh);
		sizes_used++;
	endtask

	// Half the coordinates land near the frame so in-frame pixels show up
	// even on tiny frames; the rest cover the whole coordinate range.
	function automatic coord_t pick_coord(input int span);
		if ($urandom_range(0, 1))
			return CW'($urandom_range(0, COORD_MAX));
		return CW'($urandom_range(0, span));
	endfunction

	// Endpoint a short distance away, mirrored back when it would leave range.
	function automatic coord_t nearby(input coord_t s, input int d);
		int e;
		e = int'(s) + d;
		if (e < 0 || e > COORD_MAX)
			e = int'(s) - d;
		return CW'(e);
	endfunction

	task automatic run_line(input coord_t sx, input coord_t sy, input coord_t ex,
			input coord_t ey, input int n_steps);
		push_req(REQ_LOAD, sx, sy, ex, ey);
		repeat (n_steps) push_step();
	endtask

	// Mostly whole lines with random content, some cut short or run past
	// their end, and some lone loads and steps as noise.
	task automatic random_lines(input int n_items);
		int     goal;
		int     len;
		int     n_steps;
		int     pick;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		goal = loads_sent + steps_sent + n_items;
		while (loads_sent + steps_sent < goal) begin
			sx = pick_coord(x_span);
			sy = pick_coord(y_span);
			if ($urandom_range(0, 9) == 0) begin
				ex = CW'($urandom_range(0, COORD_MAX));
				ey = CW'($urandom_range(0, COORD_MAX));
			end else begin
				ex = nearby(sx, $urandom_range(0, 24) - 12);
				ey = nearby(sy, $urandom_range(0, 24) - 12);
			end
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				len = (int'(ex) > int'(sx)) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
				if ((int'(ey) > int'(sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey)) > len)
					len = int'(ey) > int'(sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
				pick = $urandom_range(0, 99);
				if (pick < 70)
					n_steps = len;
				else if (pick < 85)
					n_steps = len + $urandom_range(1, 2);
				else
					n_steps = $urandom_range(0, len);
				// long lines get replaced by the next load
				if (n_steps > 40)
					n_steps = 40;
				run_line(sx, sy, ex, ey, n_steps);
			end else if (pick < 90) begin
				push_step();
			end else begin
				push_req(REQ_LOAD, sx, sy, ex, ey);
			end
		end
	endtask

	int frame_sizes[6][2];

	initial begin
		frame_sizes = '{'{700, 700}, '{1, 1}, '{1024, 1024}, '{0, 2047}, '{2047, 3}, '{0, 0}};
		frame_sizes[5][0] = $urandom_range(1, 1024);
		frame_sizes[5][1] = $urandom_range(1, 1024);

		req_valid    <= 1'b0;
		req_type     <= REQ_LOAD;
		start_x      <= '0;
		start_y      <= '0;
		end_x        <= '0;
		end_y        <= '0;
		cfg_wr_en    <= 1'b0;
		cfg_index    <= CFG_FRAME_WIDTH;
		cfg_data     <= '0;
		arst_n       <= 1'b0;
		tx_idle_en   = 1'b1;
		rx_idle_en   = 1'b1;
		hold_request = 1'b0;
		loads_sent   = 0;
		steps_sent   = 0;
		sizes_used   = 1;
		x_span       = 700;
		y_span       = 700;

		// Hold reset, then release it at a falling edge.
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset frame size.
		push_step();                                   // step with no line loaded
		run_line(0, 0, 0, 0, 1);                       // single pixel, then past its end
		run_line(C_MAX, C_MAX, C_MAX, C_MAX, 0);
		run_line(C_MAX, 0, C_MAX, C_MAX, 2);           // steep, replaced mid-line
		run_line(5, 9, 2, 7, 4);                       // both deltas negative: swapped ends
		run_line(3, 4, 4, 1, 3);                       // steep with dy negative, minor down
		run_line(0, C_MAX, C_MAX, 0, 1);               // full diagonal, minor down
		run_line(699, 699, 700, 700, 2);               // crosses the frame corner
		run_line(7, 2, 7, 5, 3);                       // vertical
		drain();

		// Random part, one frame size per phase.
		for (int p = 0; p < 6; p++) begin
			set_frame(frame_sizes[p][0], frame_sizes[p][1]);
			tx_idle_en = (p != 2);
			rx_idle_en = (p != 2);
			if (p == 1)
				hold_request = 1'b1;   // receiver holds off while requests keep coming
			random_lines(105);
			drain();                   // sender pauses until every result is back
		end

		$display("Covered %0d line loads and %0d steps over %0d frame sizes.",
			loads_sent, steps_sent, sizes_used);
		$display("Compared %0d results, %0d of them steps with no line in progress.",
			checked, blank_seen);
		if (pending != 0)
			$display("%0d expected results never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
